>>> sv/lkv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear key/value table.
// No dependencies; the top and lkv_match use this package.
package lkv_pkg;

	localparam int SLOT_COUNT_DEF  = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int TYPE_W   = 3;
	localparam int KEY_W    = 32;
	localparam int INDEX_W  = 4;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;

	// Packed stream widths; the data widths are rounded up to whole bytes.
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 4;

	// Request types.
	localparam logic [TYPE_W-1:0] REQ_GET     = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_GET_IDX = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_ADD     = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_SET     = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_DEL     = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ZERO_KEY  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd4;

	// Outcome of one scan over the slots.
	typedef struct packed {
		logic match;   // a slot holding the target key was seen
		logic free;    // a free slot was seen
	} lkv_hit_t;

endpackage

>>> sv/linear_key_value_table_top.sv
`timescale 1ns / 1ps
// Linear key/value table: request sequencer, slot tables and compare unit.
// Depends on lkv_pkg, lkv_ram and lkv_match.
//
// Usage:
//   Requests enter on the s_ group, results leave on the m_ group; each
//   request gives exactly one result word. s_tuser carries the request type
//   (get, get by index, add, set, delete); s_tdata carries key, index, value.
//   A word is taken when tvalid and tready are both high at a rising edge.
// Request flow:
//   Get, add, set and delete scan every slot through one compare unit, one
//   slot per cycle from the key and value RAMs, then pass S_LAST, S_DECIDE
//   and S_DONE before m_tvalid rises. Get by index reads one RAM word
//   through S_IDXRD and S_IDXGET. Zero keys, unused types and out-of-range
//   indexes go from idle straight to S_DONE. One request is in work at a
//   time; s_tready is high only while idle. The scan over the slots sets
//   the rate.
// Reset:
//   After arst_n releases, a clearing pass writes zero into every slot
//   while s_tready stays low.
// Stall:
//   The result sits in an output register; the next request is accepted
//   while it waits, and that request finishes once m_tready frees the register.
module linear_key_value_table_top #(
	parameter int SLOT_COUNT  = lkv_pkg::SLOT_COUNT_DEF,
	parameter int VALUE_WIDTH = lkv_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// req_key [31:0], req_index [35:32], req_value [67:36], zero [71:68]
	input  logic [lkv_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type [2:0]
	input  logic [lkv_pkg::TYPE_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// slot_out [3:0], key_out [35:4], value_out [67:36], zero [71:68]
	output logic [lkv_pkg::OUT_DATA_W-1:0] m_tdata,
	// status [2:0], hit [3]
	output logic [lkv_pkg::OUT_USER_W-1:0] m_tuser
);
	import lkv_pkg::*;

	localparam int AW  = $clog2(SLOT_COUNT);
	localparam int XW  = AW + SLOT_W;
	localparam int VXW = VALUE_WIDTH + VALUE_W;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_SCAN   = 8'b0000_0100,
		S_LAST   = 8'b0000_1000,
		S_DECIDE = 8'b0001_0000,
		S_IDXRD  = 8'b0010_0000,
		S_IDXGET = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// Request fields as unpacked from the stream.
	logic [KEY_W-1:0]   in_key;
	logic [INDEX_W-1:0] in_index;
	logic [VALUE_W-1:0] in_value;
	logic [XW-1:0]      in_index_x;
	logic [VXW-1:0]     in_value_x;
	logic               in_index_ok;

	assign in_key      = s_tdata[KEY_W-1:0];
	assign in_index    = s_tdata[KEY_W+INDEX_W-1:KEY_W];
	assign in_value    = s_tdata[KEY_W+INDEX_W+VALUE_W-1:KEY_W+INDEX_W];
	assign in_index_x  = XW'(in_index);
	assign in_value_x  = VXW'(in_value);
	assign in_index_ok = (in_index_x < XW'(SLOT_COUNT));

	// Held request.
	logic [TYPE_W-1:0]      type_q;
	logic [KEY_W-1:0]       key_q;
	logic [AW-1:0]          idx_q;
	logic [VALUE_WIDTH-1:0] val_q;

	// Scan counter and read pipeline.
	logic [AW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_slot_s1;

	// RAM ports.
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [KEY_W-1:0]       ram_wkey;
	logic [VALUE_WIDTH-1:0] ram_wval;
	logic [AW-1:0]          ram_raddr;
	logic [KEY_W-1:0]       ram_rkey;
	logic [VALUE_WIDTH-1:0] ram_rval;

	// Compare unit.
	lkv_hit_t               hit_s;
	logic [AW-1:0]          match_slot;
	logic [VALUE_WIDTH-1:0] match_value;
	logic [AW-1:0]          free_slot;
	logic                   scan_start;

	// Pending result and output register.
	logic                  res_ld;
	logic [STATUS_W-1:0]   res_status_d, res_status_q;
	logic                  res_hit_d, res_hit_q;
	logic [SLOT_W-1:0]     res_slot_d, res_slot_q;
	logic [KEY_W-1:0]      res_key_d, res_key_q;
	logic [VALUE_W-1:0]    res_value_d, res_value_q;

	logic                  m_tvalid_q;
	logic [STATUS_W-1:0]   m_status_q;
	logic                  m_hit_q;
	logic [SLOT_W-1:0]     m_slot_q;
	logic [KEY_W-1:0]      m_key_q;
	logic [VALUE_W-1:0]    m_value_q;
	logic                  out_free;

	// Widened views for the 4-bit slot and 32-bit value fields.
	logic [XW-1:0]  match_slot_x, free_slot_x, idx_x;
	logic [VXW-1:0] match_value_x, rval_x;

	assign match_slot_x  = XW'(match_slot);
	assign free_slot_x   = XW'(free_slot);
	assign idx_x         = XW'(idx_q);
	assign match_value_x = VXW'(match_value);
	assign rval_x        = VXW'(ram_rval);

	assign s_tready   = (state_q == S_IDLE);
	assign out_free   = !m_tvalid_q || m_tready;
	assign scan_start = (state_q == S_IDLE) && s_tvalid;
	assign ram_raddr  = (state_q == S_IDXRD) ? idx_q : cnt_q;

	lkv_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT)) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wkey),
		.raddr (ram_raddr),
		.rdata (ram_rkey)
	);

	lkv_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SLOT_COUNT)) u_value_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wval),
		.raddr (ram_raddr),
		.rdata (ram_rval)
	);

	lkv_match #(.SLOT_COUNT(SLOT_COUNT), .VALUE_WIDTH(VALUE_WIDTH)) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (scan_start),
		.rd_vld      (rd_vld_s1),
		.rd_slot     (rd_slot_s1),
		.rd_key      (ram_rkey),
		.rd_value    (ram_rval),
		.target      (key_q),
		.hit         (hit_s),
		.match_slot  (match_slot),
		.match_value (match_value),
		.free_slot   (free_slot)
	);

	// Sequencer, RAM writes and result selection.
	always_comb begin
		state_d      = state_q;
		ram_we       = 1'b0;
		ram_waddr    = cnt_q;
		ram_wkey     = '0;
		ram_wval     = '0;
		res_ld       = 1'b0;
		res_status_d = STAT_OK;
		res_hit_d    = 1'b0;
		res_slot_d   = '0;
		res_key_d    = '0;
		res_value_d  = '0;

		case (state_q)
			S_CLEAR: begin
				// Zero one slot per cycle.
				ram_we = 1'b1;
				if (cnt_q == AW'(SLOT_COUNT - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == REQ_GET_IDX) begin
						if (in_index_ok) begin
							state_d = S_IDXRD;
						end else begin
							res_ld       = 1'b1;
							res_status_d = STAT_RANGE;
							state_d      = S_DONE;
						end
					end else if (s_tuser > REQ_DEL) begin
						res_ld  = 1'b1;
						state_d = S_DONE;
					end else if (in_key == '0) begin
						res_ld       = 1'b1;
						res_status_d = STAT_ZERO_KEY;
						state_d      = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (cnt_q == AW'(SLOT_COUNT - 1)) state_d = S_LAST;
			end
			S_LAST: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				res_ld  = 1'b1;
				state_d = S_DONE;
				case (type_q)
					REQ_GET: begin
						if (hit_s.match) begin
							res_hit_d   = 1'b1;
							res_slot_d  = match_slot_x[SLOT_W-1:0];
							res_value_d = match_value_x[VALUE_W-1:0];
						end else begin
							res_status_d = STAT_NOT_FOUND;
						end
					end
					REQ_ADD: begin
						if (hit_s.free) begin
							ram_we     = 1'b1;
							ram_waddr  = free_slot;
							ram_wkey   = key_q;
							ram_wval   = val_q;
							res_hit_d  = 1'b1;
							res_slot_d = free_slot_x[SLOT_W-1:0];
						end else begin
							res_status_d = STAT_FULL;
						end
					end
					REQ_SET: begin
						if (hit_s.match) begin
							ram_we     = 1'b1;
							ram_waddr  = match_slot;
							ram_wkey   = key_q;
							ram_wval   = val_q;
							res_hit_d  = 1'b1;
							res_slot_d = match_slot_x[SLOT_W-1:0];
						end else if (hit_s.free) begin
							ram_we     = 1'b1;
							ram_waddr  = free_slot;
							ram_wkey   = key_q;
							ram_wval   = val_q;
							res_hit_d  = 1'b1;
							res_slot_d = free_slot_x[SLOT_W-1:0];
						end else begin
							res_status_d = STAT_FULL;
						end
					end
					REQ_DEL: begin
						// Absent key still answers ok, without a hit.
						if (hit_s.match) begin
							ram_we     = 1'b1;
							ram_waddr  = match_slot;
							res_hit_d  = 1'b1;
							res_slot_d = match_slot_x[SLOT_W-1:0];
						end
					end
					default: begin
					end
				endcase
			end
			S_IDXRD: begin
				state_d = S_IDXGET;
			end
			S_IDXGET: begin
				res_ld      = 1'b1;
				res_hit_d   = 1'b1;
				res_slot_d  = idx_x[SLOT_W-1:0];
				res_key_d   = ram_rkey;
				res_value_d = rval_x[VALUE_W-1:0];
				state_d     = S_DONE;
			end
			S_DONE: begin
				// Hold until the output register is free.
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == S_SCAN);
			if (state_q == S_CLEAR || state_q == S_SCAN) begin
				cnt_q <= (cnt_q == AW'(SLOT_COUNT - 1)) ? '0 : cnt_q + AW'(1);
			end else if (scan_start) begin
				cnt_q <= '0;
			end
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_slot_s1 <= cnt_q;
		if (scan_start) begin
			type_q <= s_tuser;
			key_q  <= in_key;
			idx_q  <= in_index_x[AW-1:0];
			val_q  <= in_value_x[VALUE_WIDTH-1:0];
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_hit_q    <= res_hit_d;
			res_slot_q   <= res_slot_d;
			res_key_q    <= res_key_d;
			res_value_q  <= res_value_d;
		end
		if (state_q == S_DONE && out_free) begin
			m_status_q <= res_status_q;
			m_hit_q    <= res_hit_q;
			m_slot_q   <= res_slot_q;
			m_key_q    <= res_key_q;
			m_value_q  <= res_value_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - SLOT_W - KEY_W - VALUE_W){1'b0}},
	                   m_value_q, m_key_q, m_slot_q};
	assign m_tuser  = {m_hit_q, m_status_q};

	// Tables change only during the clearing pass or the decision cycle.
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_DECIDE))
		else $error("table write outside clear or decide");

	// A hit always reports ok.
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (!m_hit_q || m_status_q == STAT_OK))
		else $error("hit with non-ok status");

	// Finishing a request presents its result on the next cycle.
	a_done_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (m_tvalid_q && state_q == S_IDLE))
		else $error("finished result not presented");

endmodule

>>> sv/lkv_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/lkv_match.sv
`timescale 1ns / 1ps
// Shared compare unit: watches slot words streaming out of the tables and
// holds the first slot matching the target key and the first free slot. Uses lkv_pkg.
module lkv_match #(
	parameter int SLOT_COUNT  = lkv_pkg::SLOT_COUNT_DEF,
	parameter int VALUE_WIDTH = lkv_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          rd_vld,
	input  logic [$clog2(SLOT_COUNT)-1:0] rd_slot,
	input  logic [lkv_pkg::KEY_W-1:0]     rd_key,
	input  logic [VALUE_WIDTH-1:0]        rd_value,
	input  logic [lkv_pkg::KEY_W-1:0]     target,
	output lkv_pkg::lkv_hit_t             hit,
	output logic [$clog2(SLOT_COUNT)-1:0] match_slot,
	output logic [VALUE_WIDTH-1:0]        match_value,
	output logic [$clog2(SLOT_COUNT)-1:0] free_slot
);
	import lkv_pkg::*;

	localparam int AW = $clog2(SLOT_COUNT);

	lkv_hit_t         hit_q;
	logic [AW-1:0]    match_slot_q;
	logic [AW-1:0]    free_slot_q;
	logic [VALUE_WIDTH-1:0] match_value_q;
	logic             eq_target;
	logic             eq_zero;

	assign eq_target = (rd_key == target);
	assign eq_zero   = (rd_key == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (start) begin
			hit_q <= '0;
		end else if (rd_vld) begin
			// Keep only the lowest slot of each kind.
			if (eq_target) hit_q.match <= 1'b1;
			if (eq_zero)   hit_q.free  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld && eq_target && !hit_q.match) begin
			match_slot_q  <= rd_slot;
			match_value_q <= rd_value;
		end
		if (rd_vld && eq_zero && !hit_q.free) begin
			free_slot_q <= rd_slot;
		end
	end

	assign hit         = hit_q;
	assign match_slot  = match_slot_q;
	assign match_value = match_value_q;
	assign free_slot   = free_slot_q;

	// A nonzero target can never be both the match and the free slot.
	a_match_free_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q.match && hit_q.free && target != '0) |-> (match_slot_q != free_slot_q))
		else $error("match and free slot coincide");

endmodule
